// ===== rtl/core/xcfd_pkg.sv =====
// Shared types and constants for the header-keyed backward-skip frame decoder.
// No dependencies; imported by xcfd_seq and the top level.
`default_nettype none
package xcfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_ZERO_SKIP = 2'd1;
    localparam logic [1:0] ST_OVERSHOOT = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/xcfd_store.sv =====
// Frame byte store: one write port, one registered read port.
// Depends on nothing but its parameter.
`default_nettype none
module xcfd_store #(
    parameter int MAX_PAYLOAD = 64,
    parameter int ADDR_W      = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [7:0]             rdata
);
    logic [7:0] mem [MAX_PAYLOAD];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/core/xcfd_seq.sv =====
// Frame-close sequencer: walks the skip chain backward through the store with
// one subtract/compare unit, then replays the frame. Depends on xcfd_pkg.
`default_nettype none
module xcfd_seq #(
    parameter int LEN_W  = 7,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic              go_ovf,
    input  wire logic [LEN_W-1:0]  go_len,
    output logic                   busy,
    output logic                   mem_we,
    output logic [ADDR_W-1:0]      mem_waddr,
    output logic                   mem_rd_en,
    output logic [ADDR_W-1:0]      mem_raddr,
    input  wire logic [7:0]        mem_rdata,
    output logic                   res_strobe,
    output xcfd_pkg::result_t      res
);
    import xcfd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WRD  = 3'd1;
    localparam logic [2:0] S_WCHK = 3'd2;
    localparam logic [2:0] S_ORD  = 3'd3;
    localparam logic [2:0] S_OEMT = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;
    localparam int CMP_W = 9;

    logic [2:0]       state_reg, state_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] n_reg, n_next;
    logic [LEN_W-1:0] k_reg, k_next;
    logic [1:0]       err_reg, err_next;
    logic [LEN_W-1:0] idx_m1;
    logic [LEN_W-1:0] n_m1;
    logic [LEN_W-1:0] idx_sub;
    logic             overshoot;
    logic             is_last;

    assign idx_m1    = idx_reg - LEN_W'(1);
    assign n_m1      = n_reg - LEN_W'(1);
    assign overshoot = {1'b0, mem_rdata} > CMP_W'(idx_reg);
    assign idx_sub   = idx_reg - mem_rdata[LEN_W-1:0];
    assign is_last   = (k_reg == n_m1);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        mem_we     = 1'b0;
        mem_rd_en  = 1'b0;
        mem_waddr  = idx_m1[ADDR_W-1:0];
        mem_raddr  = idx_m1[ADDR_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    idx_next = go_len;
                    n_next   = go_len;
                    k_next   = '0;
                    if (go_ovf)
                    begin
                        err_next   = ST_OVERFLOW;
                        state_next = S_ERR;
                    end
                    else if (go_len != '0)
                    begin
                        state_next = S_WRD;
                    end
                end
            end
            S_WRD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                if (mem_rdata == 8'h00)
                begin
                    err_next   = ST_ZERO_SKIP;
                    state_next = S_ERR;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (overshoot)
                    begin
                        err_next   = ST_OVERSHOOT;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        idx_next   = idx_sub;
                        state_next = (idx_sub == '0) ? S_ORD : S_WRD;
                    end
                end
            end
            S_ORD:
            begin
                mem_rd_en  = 1'b1;
                mem_raddr  = k_reg[ADDR_W-1:0];
                state_next = S_OEMT;
            end
            S_OEMT:
            begin
                k_next     = k_reg + LEN_W'(1);
                state_next = is_last ? S_IDLE : S_ORD;
            end
            S_ERR:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            err_reg   <= ST_DATA;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            err_reg   <= err_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign res_strobe = (state_reg == S_OEMT) || (state_reg == S_ERR);

    always_comb
    begin
        if (state_reg == S_ERR)
        begin
            res.out_byte = 8'h00;
            res.last     = 1'b1;
            res.status   = err_reg;
        end
        else
        begin
            res.out_byte = mem_rdata;
            res.last     = is_last;
            res.status   = ST_DATA;
        end
    end

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && (res.status != ST_DATA) |-> res.last)
        else $error("error request without last");
    a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WCHK) || (state_reg == S_WRD) |-> idx_reg != '0)
        else $error("skip walk at header position");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && res.last |=> state_reg == S_IDLE)
        else $error("sequencer busy after last request");
    a_replay_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ORD) |-> k_reg < n_reg)
        else $error("replay index beyond frame length");

endmodule
`default_nettype wire

// ===== rtl/core/xor_cobs_frame_decoder.sv =====
// Top level of the header-keyed backward-skip frame decoder: input capture,
// frame bookkeeping, store and sequencer. Depends on xcfd_pkg, xcfd_store, xcfd_seq.
//
// Usage:
//   Input: drive in_byte and raise start; the byte is taken at an edge where
//   start is high and busy is low. busy stays low for a byte that does not
//   close a frame.
//   A byte equal to the header key closes the open frame and opens the next one.
//   For a non-empty frame busy then rises for the close: each link of the skip
//   chain is read and then checked, then each payload byte is read and then
//   replayed. An error frame gives a single request in the cycle after its
//   chain check fails (overflow: in the cycle after the closing header).
//   Walk and replay share the single store read port.
//   Output: each request shows on out_byte, last and status for one cycle with
//   strobe high; the receiver cannot stall, so there is no backpressure.
//   Configuration: header_we with header_data writes the header key; write only
//   while busy is low.
//   Reset: rst_n low clears the key, leaves the decoder hunting for a header
//   and returns the sequencer to idle. Store contents are not cleared.
`default_nettype none
module xor_cobs_frame_decoder #(
    parameter int MAX_PAYLOAD = xcfd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [7:0] in_byte,
    input  wire logic       header_we,
    input  wire logic [7:0] header_data,
    output logic            strobe,
    output logic [7:0]      out_byte,
    output logic            last,
    output logic [1:0]      status
);
    import xcfd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PAYLOAD);
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]       header_reg;
    logic [LEN_W-1:0] len_reg;
    logic             in_frame_reg;
    logic             ovf_reg;
    logic             accept;
    logic             is_header;
    logic             store_byte;
    logic             go;
    logic             seq_we;
    logic [ADDR_W-1:0] seq_waddr;
    logic             rd_en;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]       rdata;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    result_t          res;

    assign accept     = start && !busy;
    assign is_header  = (in_byte == header_reg);
    assign go         = accept && is_header && in_frame_reg;
    assign store_byte = accept && !is_header && in_frame_reg && !ovf_reg
                        && (len_reg != LEN_W'(MAX_PAYLOAD));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= 8'h00;
            len_reg      <= '0;
            in_frame_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (header_we)
            begin
                header_reg <= header_data;
            end
            if (accept)
            begin
                if (is_header)
                begin
                    in_frame_reg <= 1'b1;
                    len_reg      <= '0;
                    ovf_reg      <= 1'b0;
                end
                else if (in_frame_reg && !ovf_reg)
                begin
                    if (len_reg == LEN_W'(MAX_PAYLOAD))
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        len_reg <= len_reg + LEN_W'(1);
                    end
                end
            end
        end
    end

    assign mem_we    = store_byte || seq_we;
    assign mem_waddr = seq_we ? seq_waddr : len_reg[ADDR_W-1:0];
    assign mem_wdata = seq_we ? 8'h00 : (in_byte ^ header_reg);

    xcfd_store #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rd_en (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    xcfd_seq #(
        .LEN_W  (LEN_W),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .go_ovf     (ovf_reg),
        .go_len     (len_reg),
        .busy       (busy),
        .mem_we     (seq_we),
        .mem_waddr  (seq_waddr),
        .mem_rd_en  (rd_en),
        .mem_raddr  (raddr),
        .mem_rdata  (rdata),
        .res_strobe (strobe),
        .res        (res)
    );

    assign out_byte = res.out_byte;
    assign last     = res.last;
    assign status   = res.status;

endmodule
`default_nettype wire
